>>> hw/rtl/ray_box_nearest_hit_defines.svh
// Assertion macros shared by the ray box nearest hit RTL.
`ifndef RAY_BOX_NEAREST_HIT_DEFINES_SVH
`define RAY_BOX_NEAREST_HIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RBNH_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RBNH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/rbnh_pkg.sv
// Types, constants and fixed-point helpers for the ray box nearest hit block.
package rbnh_pkg;

	localparam int unsigned MAX_ENTITIES = 1024;
	localparam int NUM_AXES    = 3;
	localparam int FX_W        = 32;
	localparam int DIST_W      = 31;
	localparam int ID_W        = 10;
	localparam int PROD_W      = 2 * FX_W;
	localparam int FRAC_W      = 16;
	localparam int IN_TDATA_W  = 200;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic signed [FX_W-1:0] ORIGIN_RST   = 32'sd0;
	localparam logic signed [FX_W-1:0] INV_DIR_RST  = 32'sd65536;
	localparam logic [DIST_W-1:0]      MAX_DIST_RST = 31'd65536000;

	localparam logic signed [FX_W-1:0] FX_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [FX_W-1:0] FX_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ORIGIN_X     = 3'd0,
		REG_ORIGIN_Y     = 3'd1,
		REG_ORIGIN_Z     = 3'd2,
		REG_INV_DIR_X    = 3'd3,
		REG_INV_DIR_Y    = 3'd4,
		REG_INV_DIR_Z    = 3'd5,
		REG_MAX_DISTANCE = 3'd6
	} cfg_reg_t;

	// Sideband that travels with each box down the pipeline.
	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            last;
		logic            test;
	} box_tag_t;

	// Saturate a 33-bit signed sum to signed 32 bits.
	function automatic logic signed [FX_W-1:0] sat33(input logic signed [FX_W:0] v);
		logic signed [FX_W-1:0] r;
		if (v[FX_W] != v[FX_W-1]) begin
			r = v[FX_W] ? FX_MIN : FX_MAX;
		end else begin
			r = v[FX_W-1:0];
		end
		return r;
	endfunction

	// Drop the fraction of a full product (floor) and saturate to signed 32 bits.
	function automatic logic signed [FX_W-1:0] slab_t(input logic signed [PROD_W-1:0] p);
		logic signed [FX_W-1:0] r;
		logic                   all_ones;
		logic                   any_ones;
		all_ones = &p[PROD_W-2:FX_W+FRAC_W-1];
		any_ones = |p[PROD_W-2:FX_W+FRAC_W-1];
		if (!p[PROD_W-1] && any_ones) begin
			r = FX_MAX;
		end else if (p[PROD_W-1] && !all_ones) begin
			r = FX_MIN;
		end else begin
			r = p[FX_W+FRAC_W-1:FRAC_W];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/ray_box_nearest_hit.sv
// A frame result is raised on m_axis_tvalid from a register loaded when its last box leaves the final stage.
// One box per clock while s_axis_tready is high, through a five-stage pipeline; only the running nearest
// distance compare in the last stage is carried from one box to the next.
// s_axis_tready falls only while a result waits and another last box sits in that stage.
// Reset (arst_n low, asynchronous) empties the pipeline, clears the frame state and loads
// the default ray: origin 0, inverse direction 1.0, maximum distance 1000.0.
`include "ray_box_nearest_hit_defines.svh"

module ray_box_nearest_hit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rbnh_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [rbnh_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// centre_x, centre_y, centre_z, half_x, half_y, half_z, box_id, zero pad
	input  logic [rbnh_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// hit_found, hit_id, hit_distance, zero pad
	output logic [rbnh_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import rbnh_pkg::*;

	// Configuration.
	logic signed [FX_W-1:0] org_q [NUM_AXES];
	logic signed [FX_W-1:0] inv_q [NUM_AXES];
	logic [DIST_W-1:0]      max_dist_q;

	// Pipeline.
	logic                   en;
	logic                   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	box_tag_t               tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic signed [FX_W-1:0] cen_s1 [NUM_AXES];
	logic [DIST_W-1:0]      half_s1 [NUM_AXES];
	logic signed [FX_W-1:0] diff_s2 [NUM_AXES][2];
	logic signed [PROD_W-1:0] prod_s3 [NUM_AXES][2];
	logic signed [FX_W-1:0] lo_s4 [NUM_AXES];
	logic signed [FX_W-1:0] hi_s4 [NUM_AXES];
	logic signed [FX_W-1:0] tmin_s5;
	logic                   ok_s5;

	// Frame state and result register.
	logic                   any_hit_q;
	logic [DIST_W-1:0]      best_q;
	logic [ID_W-1:0]        best_id_q;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                   fire5;
	logic [DIST_W-1:0]      limit;
	logic                   new_hit;
	logic                   fin_any;
	logic [ID_W-1:0]        fin_id;
	logic [DIST_W-1:0]      fin_dist;

	// Combinational intermediates.
	logic signed [FX_W-1:0] diff_d [NUM_AXES][2];
	logic signed [FX_W-1:0] lo_d [NUM_AXES];
	logic signed [FX_W-1:0] hi_d [NUM_AXES];
	logic signed [FX_W-1:0] tmin_d;
	logic                   ok_d;

	// The whole pipeline holds only when a frame result cannot be handed over.
	assign en            = !(valid_s5 && tag_s5.last && out_valid_q && !m_axis_tready);
	assign s_axis_tready = en;
	assign fire5         = valid_s5 && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				org_q[a] <= ORIGIN_RST;
				inv_q[a] <= INV_DIR_RST;
			end
			max_dist_q <= MAX_DIST_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_ORIGIN_X:     org_q[0]   <= signed'(cfg_data);
				REG_ORIGIN_Y:     org_q[1]   <= signed'(cfg_data);
				REG_ORIGIN_Z:     org_q[2]   <= signed'(cfg_data);
				REG_INV_DIR_X:    inv_q[0]   <= signed'(cfg_data);
				REG_INV_DIR_Y:    inv_q[1]   <= signed'(cfg_data);
				REG_INV_DIR_Z:    inv_q[2]   <= signed'(cfg_data);
				REG_MAX_DISTANCE: max_dist_q <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Slab bounds relative to the origin.
	always_comb begin
		logic signed [FX_W:0]   b_lo;
		logic signed [FX_W:0]   b_hi;
		logic signed [FX_W-1:0] s_lo;
		logic signed [FX_W-1:0] s_hi;
		for (int a = 0; a < NUM_AXES; a++) begin
			b_lo = {cen_s1[a][FX_W-1], cen_s1[a]} - signed'({2'b00, half_s1[a]});
			b_hi = {cen_s1[a][FX_W-1], cen_s1[a]} + signed'({2'b00, half_s1[a]});
			s_lo = sat33(b_lo);
			s_hi = sat33(b_hi);
			diff_d[a][0] = sat33({s_lo[FX_W-1], s_lo} - {org_q[a][FX_W-1], org_q[a]});
			diff_d[a][1] = sat33({s_hi[FX_W-1], s_hi} - {org_q[a][FX_W-1], org_q[a]});
		end
	end

	// Per-axis entry and exit distances, ordered.
	always_comb begin
		logic signed [FX_W-1:0] ta;
		logic signed [FX_W-1:0] tb;
		for (int a = 0; a < NUM_AXES; a++) begin
			ta = slab_t(prod_s3[a][0]);
			tb = slab_t(prod_s3[a][1]);
			lo_d[a] = (ta > tb) ? tb : ta;
			hi_d[a] = (ta > tb) ? ta : tb;
		end
	end

	// Intersect the x, y and z slabs.
	always_comb begin
		logic signed [FX_W-1:0] tmin_xy;
		logic signed [FX_W-1:0] tmax_xy;
		logic                   ok_xy;
		logic                   ok_z;
		ok_xy   = !((lo_s4[0] > hi_s4[1]) || (lo_s4[1] > hi_s4[0]));
		tmin_xy = (lo_s4[1] > lo_s4[0]) ? lo_s4[1] : lo_s4[0];
		tmax_xy = (hi_s4[1] < hi_s4[0]) ? hi_s4[1] : hi_s4[0];
		ok_z    = !((tmin_xy > hi_s4[2]) || (lo_s4[2] > tmax_xy));
		tmin_d  = (lo_s4[2] > tmin_xy) ? lo_s4[2] : tmin_xy;
		ok_d    = tag_s4.test && ok_xy && ok_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cen_s1[0]  <= signed'(s_axis_tdata[31:0]);
			cen_s1[1]  <= signed'(s_axis_tdata[63:32]);
			cen_s1[2]  <= signed'(s_axis_tdata[95:64]);
			half_s1[0] <= s_axis_tdata[126:96];
			half_s1[1] <= s_axis_tdata[157:127];
			half_s1[2] <= s_axis_tdata[188:158];
			tag_s1.id   <= s_axis_tdata[198:189];
			tag_s1.last <= s_axis_tlast;
			tag_s1.test <= 32'(s_axis_tdata[198:189]) < 32'(MAX_ENTITIES);
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			for (int a = 0; a < NUM_AXES; a++) begin
				for (int s = 0; s < 2; s++) begin
					diff_s2[a][s] <= diff_d[a][s];
					prod_s3[a][s] <= PROD_W'(diff_s2[a][s]) * PROD_W'(inv_q[a]);
				end
				lo_s4[a] <= lo_d[a];
				hi_s4[a] <= hi_d[a];
			end
			tmin_s5 <= tmin_d;
			ok_s5   <= ok_d;
		end
	end

	// Running nearest hit: a tie with the limit keeps the earlier box.
	always_comb begin
		limit    = any_hit_q ? best_q : max_dist_q;
		new_hit  = ok_s5 && (tmin_s5 > 32'sd0) && (tmin_s5 < signed'({1'b0, limit}));
		fin_any  = any_hit_q || new_hit;
		fin_id   = new_hit ? tag_s5.id : best_id_q;
		fin_dist = new_hit ? tmin_s5[DIST_W-1:0] : limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_hit_q <= 1'b0;
			best_id_q <= '0;
		end else if (fire5) begin
			if (tag_s5.last) begin
				any_hit_q <= 1'b0;
				best_id_q <= '0;
			end else if (new_hit) begin
				any_hit_q <= 1'b1;
				best_id_q <= tag_s5.id;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire5 && !tag_s5.last && new_hit) begin
			best_q <= tmin_s5[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire5 && tag_s5.last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire5 && tag_s5.last) begin
			out_data_q <= {{(OUT_TDATA_W - DIST_W - ID_W - 1){1'b0}},
				fin_dist, (fin_any ? fin_id : {ID_W{1'b0}}), fin_any};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`RBNH_ASSERT_IMPL(a_result_from_last, $rose(out_valid_q), $past(valid_s5 && tag_s5.last), "result raised without a last box")
	`RBNH_ASSERT_IMPL(a_no_hit_zero_id, out_valid_q && !out_data_q[0], out_data_q[ID_W:1] == '0, "miss result carries an entity number")
	`RBNH_ASSERT_NEXT(a_stall_holds, valid_s5 && !en, valid_s5 && $stable(tag_s5) && $stable(tmin_s5), "final stage moved while stalled")
	`RBNH_ASSERT_IMPL(a_clear_on_last, $fell(any_hit_q), $past(fire5 && tag_s5.last), "frame state cleared outside a last box")

endmodule
